// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pnhi_pkg.sv =====
// ----------------------------------------------------------------------------
// pnhi_pkg
// Types, coefficients and the per-item operation program of the noise/hum
// injector.
// ----------------------------------------------------------------------------
`default_nettype none

package pnhi_pkg;

  // register indexes on the config port
  localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] CFG_LEVEL_TARGET = 2'd1;
  localparam logic [1:0] CFG_RAMP_STEPS   = 2'd2;

  localparam int unsigned PINK_TAP_COUNT = 7;

  localparam logic [31:0] PHASE_STEP_RST = 32'd4473924;
  localparam logic [15:0] LEVEL_TGT_RST  = 16'd1638;
  localparam logic [15:0] RAMP_STEPS_RST = 16'd960;
  localparam logic [31:0] LEVEL_RST      = 32'd53687091;

  // Q.24 filter coefficients
  localparam logic signed [32:0] FB_COEF [6] = '{
    33'sd16758090, 33'sd16665144, 33'sd16257122,
    33'sd14537458, 33'sd9227469, -33'sd12777528
  };
  localparam logic signed [32:0] IN_COEF [6] = '{
    33'sd931436, 33'sd1259565, 33'sd2581208,
    33'sd5209084, 33'sd8941454, -33'sd283501
  };
  localparam logic signed [32:0] PINK_DIRECT = 33'sd8995943;
  localparam logic signed [32:0] PINK_LAST   = 33'sd1944916;
  localparam logic signed [32:0] HUM_A       = 33'sd5033165;
  localparam logic signed [32:0] HUM_B       = 33'sd2516582;
  localparam logic signed [32:0] MIX_PINK    = 33'sd335544;
  localparam logic signed [32:0] MIX_HUM     = 33'sd167772;
  localparam logic signed [32:0] OUT_SCALE   = 33'sd838861;
  // ceil(2^34 / 5): floor(p / 5) = (p * RECIP5) >> 34 for any 32-bit p
  localparam logic signed [32:0] RECIP5      = 33'sh0CCCCCCCD;

  // quarter-wave sine polynomial, Q30
  localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;
  localparam logic signed [32:0] SIN_C3 = -33'sd693598672;
  localparam logic signed [32:0] SIN_C5 = 33'sd85569278;
  localparam logic signed [32:0] SIN_C7 = -33'sd5027035;

  typedef enum logic [4:0] {
    OP_TAP_FB, OP_TAP_IN, OP_DIRECT, OP_LAST, OP_PH2,
    OP_SQ, OP_P1, OP_P2, OP_P3, OP_PX,
    OP_HUMA, OP_HUMB, OP_MIXP, OP_MIXH, OP_LVL, OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
  } ucode_t;

  typedef struct packed {
    logic       load;   // capture input word
    logic       mul;    // multiply cycle of current op
    logic       wb;     // writeback cycle of current op
    logic       push;   // move result to output register
    op_e        op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } ctrl_sts_t;

  localparam logic [4:0] PROG_LAST = 5'd30;

  function automatic ucode_t ucode(input logic [4:0] step);
    ucode_t u;
    u.idx = 3'd0;
    u.op  = OP_OUT;
    if (step < 5'd12) begin
      u.op  = step[0] ? OP_TAP_IN : OP_TAP_FB;
      u.idx = step[3:1];
    end else begin
      case (step)
        5'd12: u.op = OP_DIRECT;
        5'd13: u.op = OP_LAST;
        5'd14: u.op = OP_PH2;
        5'd15: u.op = OP_SQ;
        5'd16: u.op = OP_P1;
        5'd17: u.op = OP_P2;
        5'd18: u.op = OP_P3;
        5'd19: u.op = OP_PX;
        5'd20: begin u.op = OP_SQ; u.idx = 3'd1; end
        5'd21: begin u.op = OP_P1; u.idx = 3'd1; end
        5'd22: begin u.op = OP_P2; u.idx = 3'd1; end
        5'd23: begin u.op = OP_P3; u.idx = 3'd1; end
        5'd24: begin u.op = OP_PX; u.idx = 3'd1; end
        5'd25: u.op = OP_HUMA;
        5'd26: u.op = OP_HUMB;
        5'd27: u.op = OP_MIXP;
        5'd28: u.op = OP_MIXH;
        5'd29: u.op = OP_LVL;
        default: u.op = OP_OUT;
      endcase
    end
    return u;
  endfunction

  // shift right rounding half up
  function automatic logic signed [67:0] rshr(input logic signed [67:0] v,
                                              input int unsigned n);
    logic signed [67:0] half;
    half = 68'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pnhi_cfg.sv =====
// ----------------------------------------------------------------------------
// pnhi_cfg
// Config registers, level ramp state and a serial divider for the ramp step.
// ----------------------------------------------------------------------------
`default_nettype none

module pnhi_cfg (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         step_i,
  output logic [31:0] phase_step_o,
  output logic [31:0] level_o,
  output logic        div_busy_o
);
  import pnhi_pkg::*;

  logic [31:0] phase_step_q;
  logic [15:0] ramp_steps_q;
  logic [15:0] latched_q;
  logic [31:0] level_q;
  logic [31:0] inc_q;
  logic [15:0] ramp_left_q;
  // divider
  logic [32:0] n_q;
  logic [15:0] rem_q;
  logic [15:0] d_q;
  logic        neg_q;
  logic [5:0]  cnt_q;

  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_sub;
  logic [32:0] quot;
  logic [32:0] goal;
  logic [32:0] diff;
  logic [32:0] mag;
  logic        tgt_wr;

  assign rem_sh  = {rem_q, n_q[32]};
  assign ge      = rem_sh >= {1'b0, d_q};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign quot    = {n_q[31:0], ge};
  assign goal    = {2'b00, cfg_data_i[15:0], 15'd0};
  assign diff    = goal - {1'b0, level_q};
  assign mag     = diff[32] ? (33'd0 - diff) : diff;
  assign tgt_wr  = cfg_we_i && (cfg_idx_i == CFG_LEVEL_TARGET)
                   && (cfg_data_i[15:0] != latched_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      ramp_steps_q <= RAMP_STEPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        CFG_RAMP_STEPS: ramp_steps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q   <= LEVEL_TGT_RST;
      level_q     <= LEVEL_RST;
      inc_q       <= '0;
      ramp_left_q <= '0;
      cnt_q       <= '0;
    end else if (tgt_wr) begin
      latched_q <= cfg_data_i[15:0];
      if (ramp_steps_q == 16'd0) begin
        level_q     <= goal[31:0];
        ramp_left_q <= '0;
        inc_q       <= '0;
        cnt_q       <= '0;
      end else begin
        ramp_left_q <= ramp_steps_q;
        cnt_q       <= 6'd33;
      end
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        inc_q <= neg_q ? (32'd0 - quot[31:0]) : quot[31:0];
      end
    end else if (step_i && (ramp_left_q != 16'd0)) begin
      ramp_left_q <= ramp_left_q - 16'd1;
      if (ramp_left_q != 16'd1) level_q <= level_q + inc_q;
      else level_q <= {1'b0, latched_q, 15'd0};
    end
  end

  // datapath of the divider, no reset needed
  always_ff @(posedge clk_i) begin
    if (tgt_wr) begin
      n_q   <= mag;
      rem_q <= '0;
      d_q   <= ramp_steps_q;
      neg_q <= diff[32];
    end else if (cnt_q != 6'd0) begin
      rem_q <= ge ? rem_sub[15:0] : rem_sh[15:0];
      n_q   <= quot;
    end
  end

  assign phase_step_o = phase_step_q;
  assign level_o      = level_q;
  assign div_busy_o   = cnt_q != 6'd0;

endmodule

`default_nettype wire

// ===== hdl/pnhi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnhi_ctrl
// Sequencer: walks the operation program, with a multiply state and a writeback
// state for each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module pnhi_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  pnhi_pkg::ctrl_sts_t  sts_i,
  output pnhi_pkg::dp_cmd_t    cmd_o
);
  import pnhi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WB   = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  ucode_t     uc;
  logic       accept;

  assign uc         = ucode(step_q);
  assign in_ready_o = (state_q == S_IDLE) && !sts_i.div_busy;
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: if (accept) begin
        state_d = S_MUL;
        step_d  = '0;
      end
      S_MUL: state_d = S_WB;
      S_WB: begin
        if (step_q == PROG_LAST) state_d = S_DONE;
        else begin
          state_d = S_MUL;
          step_d  = step_q + 5'd1;
        end
      end
      S_DONE: if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.mul  = state_q == S_MUL;
  assign cmd_o.wb   = state_q == S_WB;
  assign cmd_o.push = (state_q == S_DONE) && !sts_i.out_busy;
  assign cmd_o.op   = uc.op;
  assign cmd_o.idx  = uc.idx;

endmodule

`default_nettype wire

// ===== hdl/pnhi_dp.sv =====
// ----------------------------------------------------------------------------
// pnhi_dp
// Datapath: one shared 33x33 multiplier, pink filter taps, hum phase, sine
// polynomial and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnhi_dp #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pnhi_pkg::dp_cmd_t  cmd_i,
  input  wire  [23:0]        audio_i,
  input  wire  [23:0]        white_i,
  input  wire  [31:0]        phase_step_i,
  input  wire  [31:0]        level_i,
  output logic [23:0]        out_data_o,
  output logic               out_valid_o,
  input  wire                out_ready_i
);
  import pnhi_pkg::*;

  // table index width; depth is a power of two
  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] IDX_MASK = ~((32'd1 << (32 - IDX_W)) - 32'd1);

  logic signed [31:0] tap_q [PINK_TAP_COUNT];
  logic signed [24:0] w_q;
  logic signed [23:0] audio_q;
  logic signed [32:0] pink_q;
  logic [31:0]        phase_q;
  logic [31:0]        ph2_q;
  logic [30:0]        x_q;
  logic [30:0]        x2_q;
  logic [1:0]         quad_q;
  logic signed [32:0] t_q;
  logic signed [23:0] sa_q, sb_q;
  logic signed [24:0] hum_q;
  logic signed [32:0] mix_q;
  logic signed [32:0] scaled_q;
  logic signed [65:0] p_q;
  logic signed [67:0] sum_q;
  logic signed [23:0] res_q;
  logic [23:0]        out_q;
  logic               out_valid_q;

  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        ang;
  logic [30:0]        x_c;
  logic signed [67:0] p_ext;
  logic signed [67:0] s2;
  logic signed [67:0] r24;
  logic signed [67:0] r24s;
  logic signed [67:0] r29;
  logic signed [67:0] r30;
  logic signed [67:0] sv;
  logic signed [23:0] sin_v;
  logic signed [31:0] tap_v;
  logic signed [33:0] osum;

  assign ang = (cmd_i.idx[0] ? ph2_q : phase_q) & IDX_MASK;
  assign x_c = ang[30] ? (31'h40000000 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_TAP_FB: begin mul_a = 33'(tap_q[cmd_i.idx]); mul_b = FB_COEF[cmd_i.idx]; end
      OP_TAP_IN: begin mul_a = 33'(w_q); mul_b = IN_COEF[cmd_i.idx]; end
      OP_DIRECT: begin mul_a = 33'(w_q); mul_b = PINK_DIRECT; end
      OP_LAST:   begin mul_a = 33'(w_q); mul_b = PINK_LAST; end
      OP_PH2:    begin mul_a = {1'b0, phase_q}; mul_b = RECIP5; end
      OP_SQ:     begin mul_a = {2'b00, x_c}; mul_b = {2'b00, x_c}; end
      OP_P1, OP_P2, OP_P3: begin mul_a = t_q; mul_b = {2'b00, x2_q}; end
      OP_PX:     begin mul_a = t_q; mul_b = {2'b00, x_q}; end
      OP_HUMA:   begin mul_a = 33'(sa_q); mul_b = HUM_A; end
      OP_HUMB:   begin mul_a = 33'(sb_q); mul_b = HUM_B; end
      OP_MIXP:   begin mul_a = pink_q; mul_b = MIX_PINK; end
      OP_MIXH:   begin mul_a = 33'($signed({hum_q, 1'b0})); mul_b = MIX_HUM; end
      OP_LVL:    begin mul_a = mix_q; mul_b = {1'b0, level_i}; end
      OP_OUT:    begin mul_a = scaled_q; mul_b = OUT_SCALE; end
      default: ;
    endcase
  end

  assign p_ext = 68'(p_q);
  assign s2    = sum_q + p_ext;
  assign r24   = rshr(p_ext, 24);
  assign r24s  = rshr(s2, 24);
  assign r29   = rshr(p_ext, 29);
  assign r30   = rshr(p_ext, 30);
  assign tap_v = sat32(r24s);
  assign sv    = rshr(r30, 7);
  // clamp to the positive half, then apply the half-turn sign
  always_comb begin
    logic signed [23:0] mag;
    if (sv > 68'sd8388607) mag = 24'sd8388607;
    else if (sv < 68'sd0) mag = 24'sd0;
    else mag = sv[23:0];
    sin_v = quad_q[1] ? -mag : mag;
  end
  assign osum = 34'(audio_q) + 34'(rshr(p_ext, 25));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      audio_q <= audio_i;
      w_q     <= {white_i, 1'b0};
      pink_q  <= '0;
    end
    if (cmd_i.mul) begin
      p_q <= mul_a * mul_b;
      if (cmd_i.op == OP_SQ) begin
        x_q    <= x_c;
        quad_q <= ang[31:30];
      end
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_TAP_FB, OP_HUMA, OP_MIXP: sum_q <= p_ext;
        OP_TAP_IN: pink_q <= pink_q + 33'(tap_v);
        OP_DIRECT: pink_q <= pink_q + 33'(tap_q[PINK_TAP_COUNT-1]) + r24[32:0];
        OP_PH2:    ph2_q <= phase_q + p_q[65:34];
        OP_SQ: begin
          x2_q <= r30[30:0];
          t_q  <= SIN_C7;
        end
        OP_P1: t_q <= SIN_C5 + r30[32:0];
        OP_P2: t_q <= SIN_C3 + r30[32:0];
        OP_P3: t_q <= SIN_C1 + r30[32:0];
        OP_PX: begin
          if (cmd_i.idx[0]) sb_q <= sin_v;
          else sa_q <= sin_v;
        end
        OP_HUMB: hum_q <= r24s[24:0];
        OP_MIXH: mix_q <= r24s[32:0];
        OP_LVL:  scaled_q <= r29[32:0];
        OP_OUT: begin
          if (osum > 34'sd8388607) res_q <= 24'sh7FFFFF;
          else if (osum < -34'sd8388608) res_q <= 24'sh800000;
          else res_q <= osum[23:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.push) out_q <= res_q;
  end

  // filter taps and hum phase are state that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PINK_TAP_COUNT; i++) tap_q[i] <= '0;
    end else begin
      if (cmd_i.wb && cmd_i.op == OP_TAP_IN) tap_q[cmd_i.idx] <= tap_v;
      if (cmd_i.wb && cmd_i.op == OP_LAST) tap_q[PINK_TAP_COUNT-1] <= sat32(r24);
      if (cmd_i.wb && cmd_i.op == OP_OUT) phase_q <= phase_q + phase_step_i;
      if (cmd_i.push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/pink_noise_hum_injector_core.sv =====
// Each accepted input word runs 31 operations of multiply and writeback on one
//   shared 33x33 multiplier, then waits for the output register to be free.
// A new input word is taken only after the previous one has been pushed out.
// A level_target write that starts a ramp holds s_axis_tready low while the
//   serial divider forms the ramp step.
// Reset (rst_ni, async low): taps, phase, level state and registers to defaults.
`default_nettype none

// ----------------------------------------------------------------------------
// pink_noise_hum_injector_core
// Adds level-ramped pink noise and two-tone hum to a Q1.23 audio stream.
// ----------------------------------------------------------------------------
module pink_noise_hum_injector_core #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,  // [23:0] audio_sample, [47:24] white_sample
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [23:0] mixed_sample
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i
);
  import pnhi_pkg::*;

  dp_cmd_t     cmd;
  ctrl_sts_t   sts;
  logic [31:0] phase_step;
  logic [31:0] level;
  logic        div_busy;

  assign sts.div_busy = div_busy;
  assign sts.out_busy = m_axis_tvalid && !m_axis_tready;

  pnhi_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .step_i       (cmd.load),
    .phase_step_o (phase_step),
    .level_o      (level),
    .div_busy_o   (div_busy)
  );

  pnhi_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pnhi_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .audio_i      (s_axis_tdata[23:0]),
    .white_i      (s_axis_tdata[47:24]),
    .phase_step_i (phase_step),
    .level_i      (level),
    .out_data_o   (m_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
               "input accepted while previous word in flight")
  `ASSERT_IMPL(a_push_slot_free, cmd.push, !m_axis_tvalid || m_axis_tready,
               "output word overwritten before taken")
  `ASSERT_IMPL(a_no_accept_div, div_busy, !s_axis_tready,
               "input accepted during ramp division")

endmodule

`default_nettype wire

// ===== tb/pnhi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pnhi_checker
// Watches the input, output and config ports of the noise/hum injector, keeps
// its own model of filter, hum and level state, and checks every output word.
// ----------------------------------------------------------------------------
module pnhi_checker #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [47:0] s_axis_tdata,  // [23:0] audio_sample, [47:24] white_sample
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [23:0] m_axis_tdata,  // [23:0] mixed_sample
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  import pnhi_pkg::*;

  localparam longint FB_K [6] = '{16758090, 16665144, 16257122, 14537458, 9227469, -12777528};
  localparam longint IN_K [6] = '{931436, 1259565, 2581208, 5209084, 8941454, -283501};
  localparam longint K_DIRECT = 8995943;
  localparam longint K_LAST   = 1944916;
  localparam longint K_HUM_A  = 5033165;
  localparam longint K_HUM_B  = 2516582;
  localparam longint K_MIX_P  = 335544;
  localparam longint K_MIX_H  = 167772;
  localparam longint K_OUT    = 838861;

  logic signed [23:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [31:0] taps [7];
  logic [31:0] phase_acc, level_now, step_reg;
  logic signed [31:0] level_inc;
  logic [15:0] ramp_cnt, tgt_latched, ramp_reg;
  logic [23:0] mixed_q [$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = mixed_q.size();

  function automatic longint rnd_shr(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // quarter-wave polynomial sine, Q1.23
  function automatic logic signed [23:0] sine_at(logic [31:0] ang);
    longint r, x, x2, t;
    r  = longint'(ang[29:0]);
    x  = ang[30] ? (64'sd1 <<< 30) - r : r;
    x2 = rnd_shr(x * x, 30);
    t  = -5027035;
    t  = 85569278 + rnd_shr(t * x2, 30);
    t  = -693598672 + rnd_shr(t * x2, 30);
    t  = 1686629713 + rnd_shr(t * x2, 30);
    t  = rnd_shr(rnd_shr(t * x, 30), 7);
    if (t > 8388607) t = 8388607;
    if (t < 0) t = 0;
    return ang[31] ? -t : t;
  endfunction

  function automatic longint rom_at(logic [31:0] ph);
    logic [63:0] ix;
    ix = ({32'd0, ph} * 64'(SINE_TABLE_DEPTH)) >> 32;
    return longint'(sine_rom[ix % SINE_TABLE_DEPTH]);
  endfunction

  task automatic mix_sample(input logic [47:0] word);
    longint audio, w, pink, acc, hum, mixv, scaled, noise, total;
    logic [31:0] ph2;
    audio = longint'($signed(word[23:0]));
    w     = longint'($signed(word[47:24])) * 2;
    if (ramp_cnt > 0) begin
      ramp_cnt = ramp_cnt - 1;
      if (ramp_cnt > 0) level_now = level_now + level_inc;
      else level_now = {1'b0, tgt_latched, 15'd0};
    end
    pink = 0;
    for (int i = 0; i < 6; i++) begin
      acc = FB_K[i] * longint'(taps[i]) + IN_K[i] * w;
      taps[i] = clip32(rnd_shr(acc, 24));
      pink += longint'(taps[i]);
    end
    pink += longint'(taps[6]) + rnd_shr(w * K_DIRECT, 24);
    taps[6] = clip32(rnd_shr(w * K_LAST, 24));
    ph2 = 32'(({32'd0, phase_acc} * 64'd6) / 64'd5);
    hum = rnd_shr(rom_at(phase_acc) * K_HUM_A + rom_at(ph2) * K_HUM_B, 24);
    phase_acc = phase_acc + step_reg;
    mixv   = rnd_shr(pink * K_MIX_P + hum * 2 * K_MIX_H, 24);
    scaled = rnd_shr(mixv * longint'(level_now), 29);
    noise  = rnd_shr(scaled * K_OUT, 25);
    total  = audio + noise;
    if (total > 8388607) total = 8388607;
    if (total < -8388608) total = -8388608;
    mixed_q.push_back(total[23:0]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    longint goal;
    if (idx == CFG_PHASE_STEP) begin
      step_reg = val;
    end else if (idx == CFG_LEVEL_TARGET) begin
      if (val[15:0] != tgt_latched) begin
        tgt_latched = val[15:0];
        goal = longint'(val[15:0]) <<< 15;
        if (ramp_reg == 0) begin
          level_now = goal[31:0];
          ramp_cnt  = 0;
          level_inc = 0;
        end else begin
          ramp_cnt  = ramp_reg;
          level_inc = 32'((goal - longint'(level_now)) / longint'(ramp_reg));
        end
      end
    end else if (idx == CFG_RAMP_STEPS) begin
      ramp_reg = val[15:0];
    end
  endtask

  initial begin
    for (int k = 0; k < SINE_TABLE_DEPTH; k++)
      sine_rom[k] = sine_at(32'((64'(k) << 32) / 64'(SINE_TABLE_DEPTH)));
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) taps[i] = '0;
      phase_acc   = '0;
      level_now   = LEVEL_RST;
      level_inc   = '0;
      ramp_cnt    = '0;
      tgt_latched = LEVEL_TGT_RST;
      step_reg    = PHASE_STEP_RST;
      ramp_reg    = RAMP_STEPS_RST;
      errors      = 0;
      mixed_q.delete();
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) mix_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (mixed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          if (m_axis_tdata !== mixed_q[0]) begin
            errors++;
            $display("%0t: mixed_sample mismatch, expected %h, actual %h",
                     $time, mixed_q[0], m_axis_tdata);
          end
          void'(mixed_q.pop_front());
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the noise/hum injector: directed extremes, then random sample
// streams across several level, ramp and phase settings with random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import pnhi_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  logic        clk_i, rst_ni;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata;
  logic [23:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          errors, pending;
  logic        calm, hold_req, hold_done;
  int          hold_cnt, idle_cnt, n_words, n_cfg;

  pink_noise_hum_injector_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  pnhi_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // output side: random back-pressure plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send(input logic [23:0] audio, input logic [23:0] white);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {white, audio};
    do @(posedge clk_i); while (!s_tready);
    n_words++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // some quiet audio, some near full scale to hit saturation, the rest random
  task automatic send_random();
    logic [23:0] a;
    case ($urandom_range(3))
      0: a = 24'($signed($urandom_range(2000)) - 1000);
      1: a = $urandom_range(1) ? 24'(24'h7FFFFF - $urandom_range(50))
                               : 24'(24'h800000 + $urandom_range(50));
      default: a = 24'($urandom);
    endcase
    send(a, 24'($urandom));
  endtask

  task automatic random_run(input int n);
    repeat (n) send_random();
  endtask

  initial begin
    rst_ni = 1'b0; s_tvalid = 1'b0; s_tdata = '0; cfg_we = 1'b0;
    cfg_idx = '0; cfg_data = '0; calm = 1'b0; hold_req = 1'b0;
    n_words = 0; n_cfg = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes at reset settings
    send(24'h000000, 24'h000000);
    send(24'h7FFFFF, 24'h7FFFFF);
    send(24'h800000, 24'h800000);
    send(24'h7FFFFF, 24'h800000);
    send(24'h800000, 24'h7FFFFF);
    send(24'h555555, 24'hAAAAAA);
    send(24'hAAAAAA, 24'h555555);
    send(24'h000001, 24'hFFFFFF);
    drain();

    // fast ramp to the top level, largest phase step
    write_reg(CFG_RAMP_STEPS, 32'd1);
    write_reg(CFG_LEVEL_TARGET, 32'd65535);
    write_reg(CFG_PHASE_STEP, 32'hFFFFFFFF);
    repeat (4) send(24'h7FFFF0, 24'h7FFFFF);
    repeat (4) send(24'h800010, 24'h800000);
    drain();
    write_reg(CFG_RAMP_STEPS, 32'd3);
    write_reg(CFG_LEVEL_TARGET, 32'd30000);
    random_run(60);
    drain();

    // zero ramp jumps at once; same target is ignored; unknown index ignored
    write_reg(CFG_RAMP_STEPS, 32'd0);
    write_reg(CFG_LEVEL_TARGET, 32'd0);
    write_reg(CFG_LEVEL_TARGET, 32'd0);
    write_reg(CFG_PHASE_STEP, 32'd0);
    write_reg(2'd3, 32'hFFFFFFFF);
    random_run(40);
    drain();

    // long ramp, receiver holds off while the input keeps coming
    write_reg(CFG_RAMP_STEPS, 32'd65535);
    write_reg(CFG_LEVEL_TARGET, 32'd40000);
    write_reg(CFG_PHASE_STEP, 32'h80000001);
    hold_req <= 1'b1;
    random_run(200);
    drain();

    // ramp mid-flight retarget, then no idling at all for a while
    write_reg(CFG_RAMP_STEPS, 32'd50);
    write_reg(CFG_LEVEL_TARGET, 32'd16384);
    random_run(20);
    drain();
    write_reg(CFG_LEVEL_TARGET, 32'd8000);
    write_reg(CFG_RAMP_STEPS, 32'd7);
    calm = 1'b1;
    random_run(150);
    calm = 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_RAMP_STEPS, $urandom_range(200));
      write_reg(CFG_LEVEL_TARGET, $urandom_range(65535));
      write_reg(CFG_PHASE_STEP, $urandom);
      random_run(30);
      // let the pipeline run dry mid-phase
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while (pending != 0);
      random_run(30);
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("tb_top: %0d sample words, %0d register writes, across ramp, jump,",
             n_words, n_cfg);
    $display("tb_top: saturation, long output hold-off and drained-pipeline cases");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
